@@ rtl/core/rtfpte_pkg.sv @@
// types, constants and lookup functions shared by the rtf text extractor
// no dependencies
package rtfpte_pkg;

  typedef struct packed {
    logic [15:0] in_char;
    logic        end_of_document;
  } rtfpte_in_t;

  typedef struct packed {
    logic [15:0] text_char;
    logic        last_of_run;
  } rtfpte_out_t;

  typedef enum logic [2:0] {
    PH_TEXT  = 3'd0,
    PH_SLASH = 3'd1,
    PH_WORD  = 3'd2,
    PH_PARAM = 3'd3,
    PH_HEX1  = 3'd4,
    PH_HEX2  = 3'd5
  } phase_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } ctrl_e;

  // group entry bits
  localparam int GS_IGN  = 9;
  localparam int GS_SEEN = 8;
  localparam logic [9:0] GS_RESET = 10'h001;

  localparam logic [31:0] MAG_CLAMP = 32'h8000_0001;

  // known words: skip destinations first, then line words, tab, uc, u
  localparam int KW_NUM     = 20;
  localparam int KW_MAXLEN  = 18;
  localparam int KW_SKIP_LO = 0;
  localparam int KW_SKIP_HI = 11;
  localparam int KW_LINE_LO = 12;
  localparam int KW_LINE_HI = 16;
  localparam int KW_TAB     = 17;
  localparam int KW_UC      = 18;
  localparam int KW_U       = 19;

  localparam logic [8*KW_MAXLEN-1:0] KW_STR [KW_NUM] = '{
    "fonttbl", "colortbl", "stylesheet", "info", "pict", "generator",
    "themedata", "colorschememapping", "listtable", "listoverridetable",
    "rsidtbl", "latentstyles", "par", "line", "sect", "cell", "row",
    "tab", "uc", "u"
  };
  localparam int KW_LEN [KW_NUM] = '{
    7, 8, 10, 4, 4, 9, 9, 18, 9, 17, 7, 12, 3, 4, 4, 4, 3, 3, 2, 1
  };

  // advance the prefix match vector by one letter at position pos
  function automatic logic [KW_NUM-1:0] kw_step(logic [KW_NUM-1:0] m, int pos,
                                                logic [15:0] c);
    logic [KW_NUM-1:0] r;
    r = '0;
    for (int w = 0; w < KW_NUM; w++) begin
      if (m[w] && pos < KW_LEN[w]) begin
        r[w] = (KW_STR[w][8*(KW_LEN[w]-1-pos) +: 8] == c[7:0]) && (c[15:8] == 8'h00);
      end
    end
    return r;
  endfunction

  function automatic logic [KW_NUM-1:0] kw_hits(logic [KW_NUM-1:0] m, int len);
    logic [KW_NUM-1:0] r;
    for (int w = 0; w < KW_NUM; w++) begin
      r[w] = m[w] && (len == KW_LEN[w]);
    end
    return r;
  endfunction

  function automatic logic is_alpha(logic [15:0] c);
    return (c >= 16'h61 && c <= 16'h7A) || (c >= 16'h41 && c <= 16'h5A);
  endfunction

  function automatic logic is_digit(logic [15:0] c);
    return c >= 16'h30 && c <= 16'h39;
  endfunction

  // bit 4 set when c is a hex digit
  function automatic logic [4:0] hex_val(logic [15:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 16'h30 && c <= 16'h39) r = {1'b1, 4'(c - 16'h30)};
    else if (c >= 16'h61 && c <= 16'h66) r = {1'b1, 4'(c - 16'h57)};
    else if (c >= 16'h41 && c <= 16'h46) r = {1'b1, 4'(c - 16'h37)};
    return r;
  endfunction

  function automatic logic [15:0] cp1252(logic [7:0] b);
    logic [15:0] r;
    r = {8'h00, b};
    if (b[7:5] == 3'b100) begin
      case (b[4:0])
        5'h00: r = 16'h20AC; 5'h01: r = 16'h0081; 5'h02: r = 16'h201A;
        5'h03: r = 16'h0192; 5'h04: r = 16'h201E; 5'h05: r = 16'h2026;
        5'h06: r = 16'h2020; 5'h07: r = 16'h2021; 5'h08: r = 16'h02C6;
        5'h09: r = 16'h2030; 5'h0A: r = 16'h0160; 5'h0B: r = 16'h2039;
        5'h0C: r = 16'h0152; 5'h0D: r = 16'h008D; 5'h0E: r = 16'h017D;
        5'h0F: r = 16'h008F; 5'h10: r = 16'h0090; 5'h11: r = 16'h2018;
        5'h12: r = 16'h2019; 5'h13: r = 16'h201C; 5'h14: r = 16'h201D;
        5'h15: r = 16'h2022; 5'h16: r = 16'h2013; 5'h17: r = 16'h2014;
        5'h18: r = 16'h02DC; 5'h19: r = 16'h2122; 5'h1A: r = 16'h0161;
        5'h1B: r = 16'h203A; 5'h1C: r = 16'h0153; 5'h1D: r = 16'h009D;
        5'h1E: r = 16'h017E; default: r = 16'h0178;
      endcase
    end
    return r;
  endfunction

endpackage

@@ rtl/core/rtf_plain_text_extractor.sv @@
// rtf plain text extractor top level: lexer, group stack memory, output queue
// depends on rtfpte_pkg
//
// channel  dir  handshake                 payload
// in       in   in_valid_i / in_stall_o   in_data_i  (rtfpte_in_t)
// out      out  out_valid_o / out_stall_i out_data_o (rtfpte_out_t)
//
// each code unit passes through two states: accept (stack read issued) and execute
// (read data used, entry written back); the registered stack memory read sets this
// up to two characters per unit go into a four-entry output queue
// in_stall_o is high in the execute cycle and while the queue lacks room for two
// reset clears control state; the stack memory needs no clearing since an entry
// below the top is always pushed before it is popped
module rtf_plain_text_extractor
  import rtfpte_pkg::*;
#(
  parameter int MAX_GROUP_DEPTH = 32,
  parameter int MAX_KEYWORD_LEN = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  rtfpte_in_t  in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rtfpte_out_t out_data_o
);

  localparam int DW  = (MAX_GROUP_DEPTH > 2) ? $clog2(MAX_GROUP_DEPTH) : 1;
  localparam int KLW = $clog2(MAX_KEYWORD_LEN + 1);

  ctrl_e state_q, state_d;
  rtfpte_in_t item_q;
  logic in_acc, out_pop;

  logic [9:0] gs_mem [MAX_GROUP_DEPTH];
  logic [9:0] rd_q;
  logic       wr_en;
  logic [DW-1:0] wr_addr;
  logic [9:0] wr_data;

  logic [9:0]        top_q, top_d;
  logic [DW-1:0]     depth_q, depth_d;
  logic [15:0]       ovf_q, ovf_d;
  phase_e            phase_q, phase_d;
  logic [KLW-1:0]    klen_q, klen_d;
  logic [KW_NUM-1:0] match_q, match_d;
  logic [31:0]       pval_q, pval_d;
  logic [1:0]        pflag_q, pflag_d;
  logic [4:0]        hex_q, hex_d;
  logic [7:0]        skip_q, skip_d;

  // output queue
  rtfpte_out_t fifo_q [4];
  logic [1:0]  rd_ptr_q, wr_ptr_q;
  logic [2:0]  cnt_q;
  logic [1:0]  n_res;
  logic [15:0] ch0, ch1;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_pop = out_valid_o && !out_stall_i;

  // control
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: in_stall_o = (cnt_q > 3'd2);
      ST_EXEC: in_stall_o = 1'b1;
      default: in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // stack memory: entries below the top, top lives in top_q
  always_ff @(posedge clk_i) begin
    if (wr_en) gs_mem[wr_addr] <= wr_data;
    if (in_acc) rd_q <= gs_mem[DW'(depth_q - 1'b1)];
    if (in_acc) item_q <= in_data_i;
  end

  // execute: lexer step on the accepted unit
  logic [15:0] c;
  logic        eod, first, has, neg, pnonneg, in_range;
  logic [KW_NUM-1:0] hits;
  logic [7:0]  ucval;
  logic [15:0] u16;
  logic [35:0] ptmp;
  logic [4:0]  hv;
  logic [DW:0] depth_inc;
  logic        do_fin;

  always_comb begin
    top_d = top_q; depth_d = depth_q; ovf_d = ovf_q; phase_d = phase_q;
    klen_d = klen_q; match_d = match_q; pval_d = pval_q; pflag_d = pflag_q;
    hex_d = hex_q; skip_d = skip_q;
    wr_en = 1'b0; wr_addr = depth_q; wr_data = top_q;
    n_res = 2'd0; ch0 = 16'h0; ch1 = 16'h0;
    c = item_q.in_char; eod = item_q.end_of_document;
    first = 1'b0; has = 1'b0; neg = 1'b0; pnonneg = 1'b0; in_range = 1'b0;
    hits = '0; ucval = 8'h0; u16 = 16'h0; ptmp = '0; hv = '0; depth_inc = '0;
    do_fin = 1'b0;

    if (state_q == ST_EXEC) begin
      for (int pass = 0; pass < 3; pass++) begin
        // pass 0: lexer, pass 1: delimiter as plain text, pass 2: end flush
        if (pass == 0) begin
          case (phase_q)
            PH_SLASH: begin
              if (is_alpha(c)) begin
                match_d = kw_step('1, 0, c);
                klen_d = KLW'(1);
                phase_d = PH_WORD;
              end else begin
                phase_d = PH_TEXT;
                if (c == 16'h27) begin
                  phase_d = PH_HEX1;
                end else if (c == 16'h2A) begin
                  if (!top_d[GS_SEEN]) begin
                    top_d[GS_SEEN] = 1'b1;
                    top_d[GS_IGN] = 1'b1;
                  end
                end else begin
                  top_d[GS_SEEN] = 1'b1;
                  if (skip_d != 8'd0) begin
                    skip_d = skip_d - 8'd1;
                  end else if (!top_d[GS_IGN]) begin
                    if (c == 16'h5C || c == 16'h7B || c == 16'h7D) begin
                      ch0 = c; n_res = 2'd1;
                    end else if (c == 16'h7E) begin
                      ch0 = 16'h20; n_res = 2'd1;
                    end else if (c == 16'h5F) begin
                      ch0 = 16'h2D; n_res = 2'd1;
                    end
                  end
                end
              end
            end
            PH_WORD: begin
              if (is_alpha(c)) begin
                if (int'(klen_d) < MAX_KEYWORD_LEN) begin
                  match_d = kw_step(match_d, int'(klen_d), c);
                  klen_d = klen_d + 1'b1;
                end
              end else if (c == 16'h2D) begin
                pflag_d = 2'b11;
                phase_d = PH_PARAM;
              end else if (is_digit(c)) begin
                pflag_d = 2'b01;
                pval_d = {28'h0, c[3:0]};
                phase_d = PH_PARAM;
              end else begin
                do_fin = 1'b1;
              end
            end
            PH_PARAM: begin
              if (is_digit(c)) begin
                ptmp = {pval_d, 3'b000} + {3'b000, pval_d, 1'b0} + {32'h0, c[3:0]};
                pval_d = (ptmp > {4'h0, MAG_CLAMP}) ? MAG_CLAMP : ptmp[31:0];
              end else begin
                do_fin = 1'b1;
              end
            end
            PH_HEX1: begin
              hex_d = hex_val(c);
              phase_d = PH_HEX2;
            end
            PH_HEX2: begin
              hv = hex_val(c);
              phase_d = PH_TEXT;
              if (hex_q[4] && hv[4]) begin
                if (skip_d != 8'd0) skip_d = skip_d - 8'd1;
                else if (!top_d[GS_IGN]) begin
                  ch0 = cp1252({hex_q[3:0], hv[3:0]}); n_res = 2'd1;
                end
              end
              hex_d = 5'd0;
            end
            default: phase_d = PH_TEXT;
          endcase
        end else if (pass == 2) begin
          do_fin = eod && (phase_d == PH_WORD || phase_d == PH_PARAM);
        end

        // finishing a control word
        if (pass != 1 && do_fin) begin
          hits = kw_hits(match_d, int'(klen_d));
          has = pflag_d[0];
          neg = pflag_d[1];
          pnonneg = !neg || (pval_d == 32'h0) || (pval_d > 32'h8000_0000);
          in_range = !pval_d[31];
          ucval = (neg || !in_range) ? 8'h00 :
                  ((pval_d > 32'd255) ? 8'hFF : pval_d[7:0]);
          if (neg) u16 = (pval_d > 32'h8000_0000) ? 16'h0 : 16'(16'h0 - pval_d[15:0]);
          else u16 = in_range ? pval_d[15:0] : 16'h0;
          first = !top_d[GS_SEEN];
          top_d[GS_SEEN] = 1'b1;
          if (first && (|hits[KW_SKIP_HI:KW_SKIP_LO])) top_d[GS_IGN] = 1'b1;
          if (skip_d != 8'd0) begin
            skip_d = skip_d - 8'd1;
          end else if (hits[KW_UC]) begin
            if (has && pnonneg) top_d[7:0] = ucval;
          end else if (hits[KW_U]) begin
            if (!top_d[GS_IGN] && has) begin
              if (n_res == 2'd0) ch0 = u16; else ch1 = u16;
              n_res = n_res + 2'd1;
            end
            skip_d = top_d[7:0];
          end else if (!top_d[GS_IGN]) begin
            if (|hits[KW_LINE_HI:KW_LINE_LO]) begin
              if (n_res == 2'd0) ch0 = 16'h0A; else ch1 = 16'h0A;
              n_res = n_res + 2'd1;
            end else if (hits[KW_TAB]) begin
              if (n_res == 2'd0) ch0 = 16'h09; else ch1 = 16'h09;
              n_res = n_res + 2'd1;
            end
          end
          phase_d = PH_TEXT; klen_d = '0; pval_d = '0; pflag_d = '0; match_d = '1;
        end

        // plain text unit: normal text phase, or the delimiter after a word
        if ((pass == 0 && phase_q == PH_TEXT) ||
            (pass == 1 && do_fin && c != 16'h20)) begin
          depth_inc = {1'b0, depth_d} + 1'b1;
          if (c == 16'h7B) begin
            if (int'(depth_inc) < MAX_GROUP_DEPTH) begin
              wr_en = 1'b1; wr_addr = depth_d; wr_data = top_d;
              top_d[GS_SEEN] = 1'b0;
              depth_d = depth_inc[DW-1:0];
            end else if (ovf_d != 16'hFFFF) begin
              ovf_d = ovf_d + 16'd1;
            end
            skip_d = 8'd0;
          end else if (c == 16'h7D) begin
            if (ovf_d != 16'd0) ovf_d = ovf_d - 16'd1;
            else if (depth_d != '0) begin
              depth_d = depth_d - 1'b1;
              top_d = rd_q;
            end
            skip_d = 8'd0;
          end else if (c == 16'h5C) begin
            phase_d = PH_SLASH;
          end else if (c == 16'h0D || c == 16'h0A) begin
            phase_d = phase_d;
          end else if (skip_d != 8'd0) begin
            skip_d = skip_d - 8'd1;
          end else if (!top_d[GS_IGN]) begin
            top_d[GS_SEEN] = 1'b1;
            if (n_res == 2'd0) ch0 = c; else ch1 = c;
            n_res = n_res + 2'd1;
          end
        end
        if (pass == 1) do_fin = 1'b0;
      end

      if (eod) begin
        top_d = GS_RESET; depth_d = '0; ovf_d = '0; hex_d = '0; skip_d = '0;
        phase_d = PH_TEXT; klen_d = '0; pval_d = '0; pflag_d = '0; match_d = '1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= GS_RESET; depth_q <= '0; ovf_q <= '0; phase_q <= PH_TEXT;
      klen_q <= '0; match_q <= '1; pval_q <= '0; pflag_q <= '0;
      hex_q <= '0; skip_q <= '0;
    end else begin
      top_q <= top_d; depth_q <= depth_d; ovf_q <= ovf_d; phase_q <= phase_d;
      klen_q <= klen_d; match_q <= match_d; pval_q <= pval_d; pflag_q <= pflag_d;
      hex_q <= hex_d; skip_q <= skip_d;
    end
  end

  // output queue, up to two writes per cycle
  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) fifo_q[wr_ptr_q] <= '{text_char: ch0, last_of_run: n_res == 2'd1};
    if (n_res == 2'd2) fifo_q[wr_ptr_q + 2'd1] <= '{text_char: ch1, last_of_run: 1'b1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0; wr_ptr_q <= '0; cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + n_res;
      if (out_pop) rd_ptr_q <= rd_ptr_q + 2'd1;
      cnt_q <= cnt_q + {1'b0, n_res} - {2'b00, out_pop};
    end
  end

  assign out_valid_o = (cnt_q != 3'd0);
  assign out_data_o  = fifo_q[rd_ptr_q];

endmodule

@@ rtl/core/rtfpte_checker.sv @@
// port-level checks for the rtf text extractor, bound to the top level
// depends on rtfpte_pkg
module rtfpte_checker
  import rtfpte_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input rtfpte_in_t  in_data_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input rtfpte_out_t out_data_o
);

  // every code unit holds the input for its execute cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken in the cycle after a transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(in_data_i)))
    else $error("stalled input changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

  // queue drains only through transactions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("result dropped without a transaction");

endmodule

bind rtf_plain_text_extractor rtfpte_checker u_rtfpte_checker (.*);
